// ----- design/decimal_fixed_point_alu_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the decimal fixed-point ALU
// Both sample on clk and are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_FIXED_POINT_ALU_DEFINES_SVH
`define DECIMAL_FIXED_POINT_ALU_DEFINES_SVH

// same-cycle implication
`define DFPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfpa assertion failed");

// next-cycle implication
`define DFPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfpa assertion failed");

`endif

// ----- design/dfpa_pkg.sv -----
// ---------------------------------------------------------------------------
// dfpa_pkg
// Shared codes, constants and helpers of the decimal fixed-point ALU.
// ---------------------------------------------------------------------------
package dfpa_pkg;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_CMP = 3'd4
  } func_t;

  // 10^8, the fixed-point scale
  localparam logic [26:0] SCALE = 27'd100000000;

  // unit depths in register stages, input capture to result register
  localparam int DIV_LAT = 95;
  localparam int MUL_LAT = 34;

  typedef struct packed {
    logic [26:0] rem;
    logic [3:0]  q;
  } step4_t;

  // four restoring steps of a division by SCALE, MSB first
  function automatic step4_t scale_step4(logic [26:0] r, logic [3:0] bits);
    step4_t      s;
    logic [27:0] t;
    s.rem = r;
    s.q   = '0;
    for (int i = 3; i >= 0; i--) begin
      t = {s.rem, bits[i]};
      if (t >= {1'b0, SCALE}) begin
        t      = t - {1'b0, SCALE};
        s.q[i] = 1'b1;
      end
      s.rem = t[26:0];
    end
    return s;
  endfunction

endpackage

// ----- design/decimal_fixed_point_alu.sv -----
// ---------------------------------------------------------------------------
// decimal_fixed_point_alu
// Streaming ALU for signed 64-bit decimal fixed point, raw value = x * 10^8.
// ---------------------------------------------------------------------------
// One word in, one word out, a new word every cycle unless the pipe stalls.
// The pipe depth is set by the divider: |a|*10^8 is a 91-bit dividend and
// the divider retires one quotient bit per stage. All paths (add, sub,
// compare, the 34-stage multiplier) are padded to the same depth so results
// leave in order. The whole pipe moves together: it stalls only while the
// output register holds a word that has not been taken, and input ready is
// simply "output register free or being drained this cycle".
// Add and sub wrap; multiply splits each operand into whole and fraction
// (truncated toward zero); divide truncates and returns zero when b is zero.
// op_safe reports the overflow test of the selected operation; compare and
// unused codes give zero with op_safe set. is_less / is_equal are given for every code.
// ---------------------------------------------------------------------------
`include "decimal_fixed_point_alu_defines.svh"

module decimal_fixed_point_alu
  import dfpa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input word
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // operand_a [63:0], operand_b [127:64]
  input  logic [2:0]   s_tuser,   // func [2:0]
  // result word
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata    // result_value [63:0], op_safe [64],
                                  // is_less [65], is_equal [66], zero [71:67]
);

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] sum;
    logic [63:0] diff;
    logic        add_ok;
    logic        sub_ok;
    logic        div_ok;
    logic        b_zero;
    logic        lt;
    logic        eq;
  } side_t;

  logic        adv;
  logic [63:0] op_a, op_b;

  side_t       t1, t1_d;
  logic [63:0] div_q;
  logic [63:0] mul_res, mul_res_d;
  logic        mul_safe, mul_safe_d;

  logic [DIV_LAT-1:0] vpipe;   // valid bit per stage

  logic [63:0] out_res;
  logic        out_safe, out_lt, out_eq;
  logic [63:0] sel_res;
  logic        sel_safe;

  assign op_a = s_tdata[63:0];
  assign op_b = s_tdata[127:64];

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // first stage of the short paths
  always_ff @(posedge clk) begin
    if (adv) begin
      t1.func   <= s_tuser;
      t1.sum    <= op_a + op_b;
      t1.diff   <= op_a - op_b;
      t1.add_ok <= !((op_a[63] == op_b[63]) && ((op_a + op_b) >> 63 != 64'(op_a[63])));
      t1.sub_ok <= !((op_a[63] != op_b[63]) && ((op_a - op_b) >> 63 != 64'(op_a[63])));
      t1.div_ok <= !((op_b == '0) ||
                     ((op_a == {1'b1, 63'b0}) && (op_b == {64{1'b1}})));
      t1.b_zero <= op_b == '0;
      t1.lt     <= $signed(op_a) < $signed(op_b);
      t1.eq     <= op_a == op_b;
    end
  end

  dfpa_delay #(.WIDTH($bits(side_t)), .DEPTH(DIV_LAT-1)) u_side_dly (
    .clk (clk),
    .en  (adv),
    .d   (t1),
    .q   (t1_d)
  );

  dfpa_div u_div (
    .clk (clk),
    .en  (adv),
    .a   (op_a),
    .b   (op_b),
    .q   (div_q)
  );

  dfpa_mul u_mul (
    .clk  (clk),
    .en   (adv),
    .a    (op_a),
    .b    (op_b),
    .res  (mul_res),
    .safe (mul_safe)
  );

  dfpa_delay #(.WIDTH(65), .DEPTH(DIV_LAT-MUL_LAT)) u_mul_dly (
    .clk (clk),
    .en  (adv),
    .d   ({mul_res, mul_safe}),
    .q   ({mul_res_d, mul_safe_d})
  );

  // pick the result of the selected operation
  always_comb begin
    case (func_t'(t1_d.func))
      FN_ADD: begin
        sel_res  = t1_d.sum;
        sel_safe = t1_d.add_ok;
      end
      FN_SUB: begin
        sel_res  = t1_d.diff;
        sel_safe = t1_d.sub_ok;
      end
      FN_MUL: begin
        sel_res  = mul_res_d;
        sel_safe = mul_safe_d;
      end
      FN_DIV: begin
        sel_res  = t1_d.b_zero ? '0 : div_q;
        sel_safe = t1_d.div_ok;
      end
      default: begin
        sel_res  = '0;
        sel_safe = 1'b1;
      end
    endcase
  end

  // valid line and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vpipe    <= {vpipe[DIV_LAT-2:0], s_tvalid};
      m_tvalid <= vpipe[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res  <= sel_res;
      out_safe <= sel_safe;
      out_lt   <= t1_d.lt;
      out_eq   <= t1_d.eq;
    end
  end

  assign m_tdata = {5'b0, out_eq, out_lt, out_safe, out_res};

  // equal operands are never less
  `DFPA_ASSERT_NOW(a_eq_not_lt, m_tvalid && m_tdata[66], !m_tdata[65])
  // a stalled pipe keeps every valid bit in place
  `DFPA_ASSERT_NEXT(a_stall_holds, !adv, $stable(vpipe))
  // draining with a bubble behind empties the output register
  `DFPA_ASSERT_NEXT(a_drain_bubble, m_tvalid && m_tready && !vpipe[DIV_LAT-1], !m_tvalid)

endmodule

// ----- design/dfpa_delay.sv -----
// ---------------------------------------------------------------------------
// dfpa_delay
// Enabled shift line that keeps side paths aligned with the long units.
// ---------------------------------------------------------------------------
module dfpa_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ----- design/dfpa_div.sv -----
// ---------------------------------------------------------------------------
// dfpa_div
// Pipelined a*10^8 / b, one restoring step per stage, truncated toward zero.
// ---------------------------------------------------------------------------
module dfpa_div
  import dfpa_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] q
);

  // |a| * 10^8 < 2^90, so the dividend fits in 91 bits
  localparam int DVD_W = 91;
  localparam int NSTEP = DVD_W;

  logic [63:0] d0_ma, d0_mb;
  logic        d0_neg;
  logic [58:0] d1_p0, d1_p1;
  logic [63:0] d1_mb;
  logic        d1_neg;

  logic [63:0]      st_rem [NSTEP+1];
  logic [DVD_W-1:0] st_dvd [NSTEP+1];
  logic [63:0]      st_q   [NSTEP+1];
  logic [63:0]      st_mb  [NSTEP+1];
  logic             st_neg [NSTEP+1];

  always_ff @(posedge clk) begin
    if (en) begin
      d0_ma  <= a[63] ? (~a + 64'd1) : a;
      d0_mb  <= b[63] ? (~b + 64'd1) : b;
      d0_neg <= a[63] ^ b[63];

      d1_p0  <= 59'(d0_ma[31:0]) * 59'(SCALE);
      d1_p1  <= 59'(d0_ma[63:32]) * 59'(SCALE);
      d1_mb  <= d0_mb;
      d1_neg <= d0_neg;

      st_rem[0] <= '0;
      st_dvd[0] <= DVD_W'(d1_p0) + {d1_p1, 32'b0};
      st_q[0]   <= '0;
      st_mb[0]  <= d1_mb;
      st_neg[0] <= d1_neg;

      q <= st_neg[NSTEP] ? (~st_q[NSTEP] + 64'd1) : st_q[NSTEP];
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    logic [64:0] t;
    logic [64:0] t_sub;
    logic        ge;

    always_comb begin
      t     = {st_rem[k], st_dvd[k][DVD_W-1]};
      t_sub = t - {1'b0, st_mb[k]};
      ge    = t >= {1'b0, st_mb[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[k+1] <= ge ? t_sub[63:0] : t[63:0];
        st_dvd[k+1] <= {st_dvd[k][DVD_W-2:0], 1'b0};
        st_q[k+1]   <= {st_q[k][62:0], ge};
        st_mb[k+1]  <= st_mb[k];
        st_neg[k+1] <= st_neg[k];
      end
    end
  end

endmodule

// ----- design/dfpa_mul.sv -----
// ---------------------------------------------------------------------------
// dfpa_mul
// Pipelined fixed-point multiply by whole/fraction split, plus range check.
// ---------------------------------------------------------------------------
module dfpa_mul
  import dfpa_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] res,
  output logic        safe
);

  localparam int NSPLIT = 16;   // 64 bits, four per stage
  localparam int NDD    = 14;   // 56 bits, four per stage
  localparam int A_DLY  = NDD - 3;
  localparam int F_DLY  = MUL_LAT - 5;

  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  function automatic pp_t pp_make(logic [63:0] x, logic [63:0] y);
    pp_t p;
    logic [63:0] lh_full, hl_full;
    p.ll    = 64'(x[31:0]) * 64'(y[31:0]);
    lh_full = 64'(x[31:0]) * 64'(y[63:32]);
    hl_full = 64'(x[63:32]) * 64'(y[31:0]);
    p.lh    = lh_full[31:0];
    p.hl    = hl_full[31:0];
    return p;
  endfunction

  function automatic logic [63:0] pp_sum(pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'b0};
  endfunction

  // input stage
  logic [63:0] m0_ma, m0_mb;
  logic        m0_sa, m0_sb;

  // split by 10^8
  logic [63:0] sp_ma [NSPLIT+1];
  logic [63:0] sp_mb [NSPLIT+1];
  logic [63:0] sp_qa [NSPLIT+1];
  logic [63:0] sp_qb [NSPLIT+1];
  logic [26:0] sp_ra [NSPLIT+1];
  logic [26:0] sp_rb [NSPLIT+1];
  logic        sp_sa [NSPLIT+1];
  logic        sp_sb [NSPLIT+1];

  // signed parts
  logic [63:0] s_aw, s_bw, s_ad, s_bd;

  // product branch
  pp_t         p1_ww, p1_wd, p1_dw;
  logic [63:0] p2_whole, p2_t1, p2_t2;
  logic [63:0] w1_p0, w1_frac;
  logic [31:0] w1_p1;
  logic [159:0] a_bus;
  logic [63:0] a_p0, a_frac;
  logic [31:0] a_p1;

  // fraction product / 10^8
  logic [55:0] dd_m   [NDD+1];
  logic [55:0] dd_q   [NDD+1];
  logic [26:0] dd_r   [NDD+1];
  logic        dd_neg [NDD+1];
  logic [63:0] dd_val;

  // range check
  logic [63:0]  f1_ll, f1_lh, f1_hl, f1_hh;
  logic         f1_zero, f1_neg;
  logic [127:0] f2_prod;
  logic         f2_zero, f2_neg;
  logic         f3_safe;
  logic         f_safe_d;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_ma <= a[63] ? (~a + 64'd1) : a;
      m0_mb <= b[63] ? (~b + 64'd1) : b;
      m0_sa <= a[63];
      m0_sb <= b[63];

      sp_ma[0] <= m0_ma;
      sp_mb[0] <= m0_mb;
      sp_qa[0] <= '0;
      sp_qb[0] <= '0;
      sp_ra[0] <= '0;
      sp_rb[0] <= '0;
      sp_sa[0] <= m0_sa;
      sp_sb[0] <= m0_sb;

      // truncation toward zero: sign goes on both parts
      s_aw <= sp_sa[NSPLIT] ? (~sp_qa[NSPLIT] + 64'd1) : sp_qa[NSPLIT];
      s_bw <= sp_sb[NSPLIT] ? (~sp_qb[NSPLIT] + 64'd1) : sp_qb[NSPLIT];
      s_ad <= sp_sa[NSPLIT] ? (~64'(sp_ra[NSPLIT]) + 64'd1) : 64'(sp_ra[NSPLIT]);
      s_bd <= sp_sb[NSPLIT] ? (~64'(sp_rb[NSPLIT]) + 64'd1) : 64'(sp_rb[NSPLIT]);
      dd_m[0]   <= 56'(sp_ra[NSPLIT]) * 56'(sp_rb[NSPLIT]);
      dd_q[0]   <= '0;
      dd_r[0]   <= '0;
      dd_neg[0] <= sp_sa[NSPLIT] ^ sp_sb[NSPLIT];

      p1_ww <= pp_make(s_aw, s_bw);
      p1_wd <= pp_make(s_aw, s_bd);
      p1_dw <= pp_make(s_bw, s_ad);

      p2_whole <= pp_sum(p1_ww);
      p2_t1    <= pp_sum(p1_wd);
      p2_t2    <= pp_sum(p1_dw);

      w1_p0   <= 64'(p2_whole[31:0]) * 64'(SCALE);
      w1_p1   <= 32'(59'(p2_whole[63:32]) * 59'(SCALE));
      w1_frac <= p2_t1 + p2_t2;

      res  <= a_p0 + {a_p1, 32'b0} + a_frac + dd_val;
      safe <= f_safe_d;

      f1_ll   <= 64'(m0_ma[31:0]) * 64'(m0_mb[31:0]);
      f1_lh   <= 64'(m0_ma[31:0]) * 64'(m0_mb[63:32]);
      f1_hl   <= 64'(m0_ma[63:32]) * 64'(m0_mb[31:0]);
      f1_hh   <= 64'(m0_ma[63:32]) * 64'(m0_mb[63:32]);
      f1_zero <= (m0_ma == '0) || (m0_mb == '0);
      f1_neg  <= m0_sa ^ m0_sb;

      f2_prod <= 128'(f1_ll) + {32'b0, f1_lh, 32'b0} + {32'b0, f1_hl, 32'b0}
               + {f1_hh, 64'b0};
      f2_zero <= f1_zero;
      f2_neg  <= f1_neg;

      // magnitude limit is 2^63 for a negative product, 2^63-1 otherwise
      f3_safe <= f2_zero || ((f2_prod[127:64] == '0) &&
                 (f2_neg ? (f2_prod[63:0] <= {1'b1, 63'b0})
                         : (f2_prod[63:0] <= {1'b0, {63{1'b1}}})));
    end
  end

  assign dd_val = dd_neg[NDD] ? (~64'(dd_q[NDD]) + 64'd1) : 64'(dd_q[NDD]);

  for (genvar k = 0; k < NSPLIT; k++) begin : g_split
    step4_t na, nb;
    always_comb begin
      na = scale_step4(sp_ra[k], sp_ma[k][63:60]);
      nb = scale_step4(sp_rb[k], sp_mb[k][63:60]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sp_ma[k+1] <= {sp_ma[k][59:0], 4'b0};
        sp_mb[k+1] <= {sp_mb[k][59:0], 4'b0};
        sp_qa[k+1] <= {sp_qa[k][59:0], na.q};
        sp_qb[k+1] <= {sp_qb[k][59:0], nb.q};
        sp_ra[k+1] <= na.rem;
        sp_rb[k+1] <= nb.rem;
        sp_sa[k+1] <= sp_sa[k];
        sp_sb[k+1] <= sp_sb[k];
      end
    end
  end

  for (genvar k = 0; k < NDD; k++) begin : g_dd
    step4_t nd;
    always_comb nd = scale_step4(dd_r[k], dd_m[k][55:52]);
    always_ff @(posedge clk) begin
      if (en) begin
        dd_m[k+1]   <= {dd_m[k][51:0], 4'b0};
        dd_q[k+1]   <= {dd_q[k][51:0], nd.q};
        dd_r[k+1]   <= nd.rem;
        dd_neg[k+1] <= dd_neg[k];
      end
    end
  end

  dfpa_delay #(.WIDTH(160), .DEPTH(A_DLY)) u_a_dly (
    .clk (clk),
    .en  (en),
    .d   ({w1_p0, w1_p1, w1_frac}),
    .q   (a_bus)
  );

  assign {a_p0, a_p1, a_frac} = a_bus;

  dfpa_delay #(.WIDTH(1), .DEPTH(F_DLY)) u_f_dly (
    .clk (clk),
    .en  (en),
    .d   (f3_safe),
    .q   (f_safe_d)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - decimal fixed-point ALU testbench
// Drives operand words with random gaps, predicts each result in the
// testbench, and compares result words in order against the prediction.
// ---------------------------------------------------------------------------
module tb;
  import dfpa_pkg::*;

  localparam int          WATCHDOG_LIMIT = 20000;
  localparam longint      FX_SCALE       = 64'sd100000000;
  localparam logic [63:0] MIN64          = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64          = 64'h7fff_ffff_ffff_ffff;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] a;
    logic [63:0] b;
  } op_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic        safe;
    logic        less;
    logic        equal;
  } alu_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;   // operand_a [63:0], operand_b [127:64]
  logic [2:0]   s_tuser = '0;   // func [2:0]
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;        // value [63:0], safe [64], less [65], equal [66]

  op_word_t pending_ops[$];
  alu_res_t expected_res[$];
  int       errors = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       hold_off = 0;
  bit       hold_done = 1'b0;
  int       accepted = 0;

  always #5 clk = ~clk;

  decimal_fixed_point_alu DUT (.*);

  // Behavioral predictor: wide signed arithmetic stands in for the overflow tests.
  function automatic alu_res_t alu_predict(op_word_t w);
    alu_res_t         r;
    longint           a, b, aw, ad, bw, bd, dd;
    logic signed [127:0] wide, q;
    r.value = '0;
    r.safe  = 1'b1;
    a = w.a;
    b = w.b;
    case (w.func)
      FN_ADD: begin
        r.value = w.a + w.b;
        wide = 128'(a) + 128'(b);
        r.safe = (wide == 128'(longint'(r.value)));
      end
      FN_SUB: begin
        r.value = w.a - w.b;
        wide = 128'(a) - 128'(b);
        r.safe = (wide == 128'(longint'(r.value)));
      end
      FN_MUL: begin
        if (b != 0) begin
          // split into whole and fraction, truncating toward zero
          aw = a / FX_SCALE; ad = a % FX_SCALE;
          bw = b / FX_SCALE; bd = b % FX_SCALE;
          dd = (ad * bd) / FX_SCALE;
          r.value = aw * bw * FX_SCALE + aw * bd + bw * ad + dd;
        end
        wide = 128'(a) * 128'(b);
        r.safe = (wide >= -(128'sd1 <<< 63)) && (wide < (128'sd1 <<< 63));
      end
      FN_DIV: begin
        if (b != 0) begin
          q = (128'(a) * 128'(FX_SCALE)) / 128'(b);
          r.value = q[63:0];
        end
        r.safe = !(b == 0 || (w.a == MIN64 && b == -1));
      end
      default: ;
    endcase
    r.less  = (a < b);
    r.equal = (a == b);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // operand with interesting shapes: extremes, scale multiples, small and random
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = ($urandom_range(0, 1) != 0) ? MIN64 : MAX64;
      1: v = 64'(longint'($urandom_range(0, 40)) - 20);
      2: v = 64'(longint'($urandom_range(0, 2000)) - 1000) * FX_SCALE;
      3, 4: v = 64'(longint'($signed($urandom())) * 1000);
      5: v = 64'(longint'($signed($urandom())));
      default: v = rand64();
    endcase
    return v;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    logic [63:0] dir_vals[8];
    op_word_t    w;
    dir_vals = '{64'd0, MIN64, MAX64, 64'hffff_ffff_ffff_ffff, 64'd100000000,
                 -64'sd150000000, 64'd1, 64'h0000_0001_0000_0000};
    // directed: each operation over the extremes and special cases
    for (int f = 0; f <= 4; f++) begin
      w.func = f[2:0];
      w.a = MIN64; w.b = 64'hffff_ffff_ffff_ffff; pending_ops.push_back(w);
      w.a = MAX64; w.b = MAX64;                   pending_ops.push_back(w);
      w.a = MIN64; w.b = 64'd0;                   pending_ops.push_back(w);
    end
    for (int i = 0; i < 8; i++) begin
      w.func = 3'(i);
      w.a = dir_vals[i];
      w.b = dir_vals[7 - i];
      pending_ops.push_back(w);
    end
    for (int i = 0; i < 630; i++) begin
      w.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      w.a = rand_operand();
      w.b = ($urandom_range(0, 15) == 0) ? w.a : rand_operand();
      if (w.func == FN_DIV && $urandom_range(0, 9) == 0) w.b = '0;
      pending_ops.push_back(w);
    end
    stim_done = 1'b1;
  end

  // reset, then wait for the end of traffic
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done && pending_ops.size() == 0 && !s_tvalid && expected_res.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // driver: offers the next word after a random gap
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_res.push_back(alu_predict({s_tuser, s_tdata[63:0], s_tdata[127:64]}));
        accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0 || pending_ops.size() == 0) begin
          s_tvalid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          op_word_t nxt;
          nxt = pending_ops.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {nxt.b, nxt.a};
          s_tuser  <= nxt.func;
          src_gap  = gap_len();
        end
      end
    end
  end

  // monitor: checks each result word, stalls at random, one long hold-off
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[63:0], '0);
        end else begin
          exp_r = expected_res.pop_front();
          if (m_tdata[63:0] !== exp_r.value)
            report_mismatch("result_value", m_tdata[63:0], exp_r.value);
          if (m_tdata[64] !== exp_r.safe)  report_mismatch("op_safe", m_tdata[64], exp_r.safe);
          if (m_tdata[65] !== exp_r.less)  report_mismatch("is_less", m_tdata[65], exp_r.less);
          if (m_tdata[66] !== exp_r.equal) report_mismatch("is_equal", m_tdata[66], exp_r.equal);
        end
      end
      if (!hold_done && accepted >= 100) begin
        hold_done = 1'b1;
        hold_off = 400;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // watchdog on cycles with no accepted word on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/dfpa_pkg.sv
design/dfpa_delay.sv
design/dfpa_div.sv
design/dfpa_mul.sv
design/decimal_fixed_point_alu.sv
sim/tb.sv
